// File: hdl/spq_pkg.sv
// Shared types and constants for the stable priority queue unit.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PRIORITY_WIDTH = 16;
    localparam int STATUS_WIDTH = 2;
    localparam int COUNT_WIDTH = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic                      op;
        logic [DATA_WIDTH-1:0]     entry_data;
        logic [PRIORITY_WIDTH-1:0] entry_priority;
    } spq_req_t;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0] status;
        logic [DATA_WIDTH-1:0]   front_data;
        logic [COUNT_WIDTH-1:0]  entry_count;
    } spq_rsp_t;

    typedef struct packed {
        logic                    load;
        logic                    exec;
        logic                    insert;
        logic                    pop;
        logic [STATUS_WIDTH-1:0] code;
    } spq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } spq_flags_t;

endpackage

`default_nettype wire

// File: hdl/spq_controller.sv
// Controller state machine for the stable priority queue unit.
// Depends on spq_pkg; drives the datapath through command signals only.
`default_nettype none

module spq_controller (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                op,
    input  spq_pkg::spq_flags_t      flags,
    output spq_pkg::spq_cmd_t        cmd,
    output logic                     busy,
    output logic                     done
);
    import spq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic op_reg;
    logic done_reg;
    logic accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.code = STATUS_OK;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = ST_IDLE;
                if (op_reg == OP_POP)
                begin
                    if (flags.empty)
                    begin
                        cmd.code = STATUS_EMPTY;
                    end
                    else
                    begin
                        cmd.pop = 1'b1;
                    end
                end
                else
                begin
                    if (flags.full)
                    begin
                        cmd.code = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op;
        end
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

endmodule

`default_nettype wire

// File: hdl/spq_datapath.sv
// Datapath of the stable priority queue unit: a sorted shift-register cell array.
// Depends on spq_pkg; obeys the commands of spq_controller.
`default_nettype none

module spq_datapath #(
    parameter int DEPTH = spq_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  spq_pkg::spq_cmd_t        cmd,
    input  spq_pkg::spq_req_t        request,
    output spq_pkg::spq_flags_t      flags,
    output spq_pkg::spq_rsp_t        response
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0]     data_reg [DEPTH];
    logic [PRIORITY_WIDTH-1:0] prio_reg [DEPTH];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [DATA_WIDTH-1:0]     item_data_reg;
    logic [PRIORITY_WIDTH-1:0] item_prio_reg;
    spq_rsp_t                  rsp_reg;
    spq_rsp_t                  rsp_next;
    logic [CNT_W+COUNT_WIDTH-1:0] count_wide;

    logic [DEPTH-1:0] ge;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_data_reg <= request.entry_data;
            item_prio_reg <= request.entry_priority;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                      valid;
        logic [DATA_WIDTH-1:0]     ins_data;
        logic [PRIORITY_WIDTH-1:0] ins_prio;
        logic [DATA_WIDTH-1:0]     pop_data;
        logic [PRIORITY_WIDTH-1:0] pop_prio;

        assign valid = (CNT_W'(i) < count_reg);
        assign ge[i] = valid && (prio_reg[i] >= item_prio_reg);

        if (i == 0)
        begin : g_head
            assign ins_data = item_data_reg;
            assign ins_prio = item_prio_reg;
        end
        else
        begin : g_body
            assign ins_data = ge[i-1] ? item_data_reg : data_reg[i-1];
            assign ins_prio = ge[i-1] ? item_prio_reg : prio_reg[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign pop_data = data_reg[i];
            assign pop_prio = prio_reg[i];
        end
        else
        begin : g_inner
            assign pop_data = data_reg[i+1];
            assign pop_prio = prio_reg[i+1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.insert)
            begin
                if (!ge[i])
                begin
                    data_reg[i] <= ins_data;
                    prio_reg[i] <= ins_prio;
                end
            end
            else if (cmd.pop)
            begin
                data_reg[i] <= pop_data;
                prio_reg[i] <= pop_prio;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_wide = {{COUNT_WIDTH{1'b0}}, count_next};

    always_comb
    begin
        rsp_next.status = cmd.code;
        rsp_next.front_data = cmd.pop ? data_reg[0] : '0;
        rsp_next.entry_count = count_wide[COUNT_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign flags.empty = (count_reg == '0);
    assign flags.full = (count_reg == CNT_W'(DEPTH));
    assign response = rsp_reg;

endmodule

`default_nettype wire

// File: hdl/stable_priority_queue_unit.sv
// Top level of the stable priority queue unit; joins controller and datapath.
// Depends on spq_pkg, spq_controller and spq_datapath.
//
//   channel    handshake          payload
//   request    start, busy        spq_req_t request
//   response   done (strobe)      spq_rsp_t response
//
// For each item, the accepting edge captures it, and the execute state then
// shifts the cell array and registers the result.
// The result is shown for one cycle with done high; busy is low in that cycle,
// so the next item may be accepted alongside it.
// Reset empties the queue at once; no clearing pass is needed.
// The receiver cannot stall, so results are never held back.
`default_nettype none

module stable_priority_queue_unit #(
    parameter int DEPTH = spq_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  spq_pkg::spq_req_t        request,
    output logic                     done,
    output spq_pkg::spq_rsp_t        response
);
    import spq_pkg::*;

    spq_cmd_t   cmd;
    spq_flags_t flags;

    spq_controller u_controller (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (request.op),
        .flags (flags),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .request  (request),
        .flags    (flags),
        .response (response)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("Result strobe without a preceding execute cycle.");

    a_single_exec: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("Execute phase lasted longer than one cycle.");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (response.status != STATUS_OK)) |-> (response.front_data == '0))
        else $error("Failed item returned data.");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (response.status == STATUS_EMPTY)) |-> (response.entry_count == '0))
        else $error("Pop on empty queue reported a non-zero count.");

endmodule

`default_nettype wire

// File: tb/stable_priority_queue_unit_tb.sv
// Self-checking testbench for stable_priority_queue_unit: directed table, then random bursts.
// Each result is checked against a typed row of the directed table or a queue model in the bench.
// Depends on spq_pkg and the stable_priority_queue_unit RTL.
`timescale 1ns / 100ps

module stable_priority_queue_unit_tb;

    import spq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 475;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]     data;
        logic [PRIORITY_WIDTH-1:0] prio;
    } held_entry_t;

    typedef struct {
        spq_req_t req;
        int       reps;
        bit       typed;
        spq_rsp_t rsp;
    } stim_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    spq_req_t request;
    logic     done;
    spq_rsp_t response;

    held_entry_t held_entries[$];
    spq_rsp_t    results_due[$];
    stim_row_t   directed_rows[$];
    int          idle_pct;
    int          mismatches = 0;
    longint      cycle_count = 0;
    int          idle_pct_by_phase[4] = '{0, 70, 0, 38};

    stable_priority_queue_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .response(response)
    );

    always #5 clk = ~clk;

    function automatic spq_rsp_t queue_model_apply(spq_req_t req);
        spq_rsp_t    rsp;
        held_entry_t ent;
        int          pos;
        rsp = '0;
        rsp.status = STATUS_OK;
        if (req.op == OP_POP)
        begin
            if (held_entries.size() == 0)
            begin
                rsp.status = STATUS_EMPTY;
            end
            else
            begin
                ent = held_entries.pop_front();
                rsp.front_data = ent.data;
            end
        end
        else if (held_entries.size() >= DEPTH)
        begin
            rsp.status = STATUS_FULL;
        end
        else
        begin
            ent.data = req.entry_data;
            ent.prio = req.entry_priority;
            pos = 0;
            while (pos < held_entries.size() && held_entries[pos].prio >= ent.prio)
            begin
                pos++;
            end
            held_entries.insert(pos, ent);
        end
        rsp.entry_count = COUNT_WIDTH'(held_entries.size());
        return rsp;
    endfunction

    task automatic add_row(logic op, logic [DATA_WIDTH-1:0] data,
                           logic [PRIORITY_WIDTH-1:0] prio, int reps, bit typed,
                           logic [STATUS_WIDTH-1:0] status,
                           logic [DATA_WIDTH-1:0] front, logic [COUNT_WIDTH-1:0] count);
        stim_row_t row;
        row.req.op = op;
        row.req.entry_data = data;
        row.req.entry_priority = prio;
        row.reps = reps;
        row.typed = typed;
        row.rsp.status = status;
        row.rsp.front_data = front;
        row.rsp.entry_count = count;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(spq_req_t req, bit typed, spq_rsp_t typed_rsp);
        spq_rsp_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        predicted = queue_model_apply(req);
        results_due.push_back(typed ? typed_rsp : predicted);
    endtask

    function automatic spq_req_t random_item(int insert_pct);
        spq_req_t req;
        int       pick;
        req.op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP;
        pick = $urandom_range(7);
        req.entry_data = (pick == 0) ? '0 : (pick == 1) ? '1 : DATA_WIDTH'($urandom);
        pick = $urandom_range(9);
        if (pick < 5)
        begin
            req.entry_priority = PRIORITY_WIDTH'($urandom_range(3));
        end
        else if (pick < 8)
        begin
            req.entry_priority = PRIORITY_WIDTH'($urandom);
        end
        else
        begin
            req.entry_priority = (pick == 8) ? '0 : '1;
        end
        return req;
    endfunction

    always @(posedge clk)
    begin : check_results
        spq_rsp_t want;
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
            begin
                $error("result with no item outstanding: status %0d data %h count %0d",
                       response.status, response.front_data, response.entry_count);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                if (response.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, response.status);
                    mismatches++;
                end
                if (response.front_data !== want.front_data)
                begin
                    $error("front_data: expected %h, actual %h",
                           want.front_data, response.front_data);
                    mismatches++;
                end
                if (response.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, response.entry_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("stable_priority_queue_unit verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        spq_rsp_t none;
        int       phase;
        int       sent;
        int       burst;
        int       insert_pct;
        none = '0;
        rst_n <= 1'b0;
        start <= 1'b0;
        request <= '0;
        idle_pct = 0;

        // Extremes and the empty case first, then ties, then filling to overflow.
        add_row(OP_POP, '0, '0, 1, 1'b1, STATUS_EMPTY, '0, 5'd0);
        add_row(OP_INSERT, '1, '1, 1, 1'b1, STATUS_OK, '0, 5'd1);
        add_row(OP_INSERT, '0, '0, 1, 1'b1, STATUS_OK, '0, 5'd2);
        add_row(OP_POP, '0, '1, 1, 1'b1, STATUS_OK, '1, 5'd1);
        add_row(OP_POP, '1, '0, 1, 1'b1, STATUS_OK, '0, 5'd0);
        add_row(OP_POP, '1, '1, 1, 1'b1, STATUS_EMPTY, '0, 5'd0);
        add_row(OP_INSERT, 32'h0000_0001, 16'd7, 1, 1'b0, STATUS_OK, '0, '0);
        add_row(OP_INSERT, 32'h0000_0002, 16'd7, 1, 1'b0, STATUS_OK, '0, '0);
        add_row(OP_INSERT, 32'h0000_0003, 16'd7, 1, 1'b0, STATUS_OK, '0, '0);
        add_row(OP_INSERT, 32'h0000_0004, 16'd8, 1, 1'b0, STATUS_OK, '0, '0);
        add_row(OP_INSERT, 32'h0000_0005, 16'd7, 1, 1'b0, STATUS_OK, '0, '0);
        add_row(OP_POP, '0, '0, 2, 1'b0, STATUS_OK, '0, '0);
        add_row(OP_INSERT, 32'hA5A5_5A5A, 16'd7, DEPTH - 3, 1'b0, STATUS_OK, '0, '0);
        add_row(OP_INSERT, 32'hDEAD_BEEF, 16'hFFFF, 1, 1'b1, STATUS_FULL, '0, 5'd16);
        add_row(OP_POP, '0, '0, 1, 1'b0, STATUS_OK, '0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            repeat (directed_rows[r].reps)
            begin
                send_item(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].rsp);
            end
        end

        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct = idle_pct_by_phase[phase];
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                burst = $urandom_range(1, 40);
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 50;
                    default: insert_pct = 15;
                endcase
                repeat (burst)
                begin
                    send_item(random_item(insert_pct), 1'b0, none);
                    sent++;
                end
            end
        end
        start <= 1'b0;

        while (results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("stable_priority_queue_unit verification clean");
        end
        else
        begin
            $display("stable_priority_queue_unit verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/spq_pkg.sv
hdl/spq_controller.sv
hdl/spq_datapath.sv
hdl/stable_priority_queue_unit.sv
tb/stable_priority_queue_unit_tb.sv
